@@ hdl/iirdf2_pkg.sv @@
package iirdf2_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_W       = 24;
  localparam int WORD_W       = 24;
  localparam int FRAC_W       = 20;
  localparam int NUM_REGS     = 5;
  localparam int REG_IDX_W    = 3;
  localparam int TAP_W        = 2;
  localparam int PROD_W       = COEF_W + WORD_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int RND_W        = ACC_W - FRAC_W;

  localparam logic [REG_IDX_W-1:0] REG_B0 = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_B1 = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_B2 = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_A1 = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_A2 = REG_IDX_W'(4);

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [RND_W-1:0] WORD_HI    = RND_W'((1 << (WORD_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] WORD_LO    = -RND_W'(1 << (WORD_W - 1));
  localparam logic signed [RND_W-1:0] SAMPLE_HI  = RND_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAMPLE_LO  = -RND_W'(1 << (SAMPLE_WIDTH - 1));

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           clear_state;
    logic                           last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;
    logic                           last_out;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_FB_DRAIN,
    ST_W0,
    ST_FF,
    ST_FF_DRAIN,
    ST_Y
  } state_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_CLEAR,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    acc_op_t          acc_op;
    logic [TAP_W-1:0] tap;
    logic             fb;
    logic             w0_load;
    logic             y_load;
  } mac_ctrl_t;

endpackage

@@ hdl/iirdf2_mac.sv @@
module iirdf2_mac (
  input  logic                                     clk,
  input  iirdf2_pkg::acc_op_t                      acc_op,
  input  logic signed [iirdf2_pkg::COEF_W-1:0]     coef,
  input  logic signed [iirdf2_pkg::WORD_W-1:0]     word,
  input  logic signed [iirdf2_pkg::SAMPLE_WIDTH-1:0] x,
  output logic signed [iirdf2_pkg::WORD_W-1:0]     w0_word,
  output logic                                     w0_ovf,
  output logic signed [iirdf2_pkg::SAMPLE_WIDTH-1:0] y_sample,
  output logic                                     y_ovf
);

  logic signed [iirdf2_pkg::PROD_W-1:0] prod;
  logic signed [iirdf2_pkg::ACC_W-1:0]  acc;
  logic signed [iirdf2_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [iirdf2_pkg::RND_W-1:0]  rnd;

  always_ff @(posedge clk) begin
    prod <= coef * word;
  end

  always_ff @(posedge clk) begin
    case (acc_op)
      iirdf2_pkg::ACC_LOAD_X: acc <= iirdf2_pkg::ACC_W'(x) <<< iirdf2_pkg::FRAC_W;
      iirdf2_pkg::ACC_CLEAR:  acc <= '0;
      iirdf2_pkg::ACC_ADD:    acc <= acc + iirdf2_pkg::ACC_W'(prod);
      iirdf2_pkg::ACC_SUB:    acc <= acc - iirdf2_pkg::ACC_W'(prod);
      default:                acc <= acc;
    endcase
  end

  assign acc_rnd = acc + iirdf2_pkg::ROUND_HALF;
  assign rnd     = acc_rnd[iirdf2_pkg::ACC_W-1:iirdf2_pkg::FRAC_W];

  always_comb begin
    w0_ovf = 1'b1;
    if (rnd > iirdf2_pkg::WORD_HI) begin
      w0_word = iirdf2_pkg::WORD_HI[iirdf2_pkg::WORD_W-1:0];
    end else if (rnd < iirdf2_pkg::WORD_LO) begin
      w0_word = iirdf2_pkg::WORD_LO[iirdf2_pkg::WORD_W-1:0];
    end else begin
      w0_word = rnd[iirdf2_pkg::WORD_W-1:0];
      w0_ovf  = 1'b0;
    end
  end

  always_comb begin
    y_ovf = 1'b1;
    if (rnd > iirdf2_pkg::SAMPLE_HI) begin
      y_sample = iirdf2_pkg::SAMPLE_HI[iirdf2_pkg::SAMPLE_WIDTH-1:0];
    end else if (rnd < iirdf2_pkg::SAMPLE_LO) begin
      y_sample = iirdf2_pkg::SAMPLE_LO[iirdf2_pkg::SAMPLE_WIDTH-1:0];
    end else begin
      y_sample = rnd[iirdf2_pkg::SAMPLE_WIDTH-1:0];
      y_ovf    = 1'b0;
    end
  end

endmodule

@@ hdl/iirdf2_ctrl.sv @@
module iirdf2_ctrl #(
  parameter int FILTER_ORDER = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_free,
  output logic                  busy,
  output iirdf2_pkg::mac_ctrl_t ctrl
);

  localparam int FB_TAPS = (FILTER_ORDER < 2) ? FILTER_ORDER : 2;
  localparam logic [iirdf2_pkg::TAP_W-1:0] FB_LAST = iirdf2_pkg::TAP_W'(FB_TAPS - 1);
  localparam logic [iirdf2_pkg::TAP_W-1:0] FF_LAST = iirdf2_pkg::TAP_W'(FB_TAPS);

  iirdf2_pkg::state_t               state, state_next;
  logic [iirdf2_pkg::TAP_W-1:0]     cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iirdf2_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      iirdf2_pkg::ST_IDLE:     if (in_valid) state_next = iirdf2_pkg::ST_FB;
      iirdf2_pkg::ST_FB:       if (cnt == FB_LAST) state_next = iirdf2_pkg::ST_FB_DRAIN;
      iirdf2_pkg::ST_FB_DRAIN: state_next = iirdf2_pkg::ST_W0;
      iirdf2_pkg::ST_W0:       state_next = iirdf2_pkg::ST_FF;
      iirdf2_pkg::ST_FF:       if (cnt == FF_LAST) state_next = iirdf2_pkg::ST_FF_DRAIN;
      iirdf2_pkg::ST_FF_DRAIN: state_next = iirdf2_pkg::ST_Y;
      iirdf2_pkg::ST_Y:        if (out_free) state_next = iirdf2_pkg::ST_IDLE;
      default:                 state_next = iirdf2_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      iirdf2_pkg::ST_FB, iirdf2_pkg::ST_FF: cnt_next = cnt + 1'b1;
      default:                              cnt_next = '0;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    ctrl.acc_op  = iirdf2_pkg::ACC_HOLD;
    ctrl.tap     = '0;
    ctrl.fb      = 1'b0;
    ctrl.w0_load = 1'b0;
    ctrl.y_load  = 1'b0;
    case (state)
      iirdf2_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_valid) ctrl.acc_op = iirdf2_pkg::ACC_LOAD_X;
      end
      iirdf2_pkg::ST_FB: begin
        ctrl.fb  = 1'b1;
        ctrl.tap = cnt + 1'b1;
        if (cnt != '0) ctrl.acc_op = iirdf2_pkg::ACC_SUB;
      end
      iirdf2_pkg::ST_FB_DRAIN: ctrl.acc_op = iirdf2_pkg::ACC_SUB;
      iirdf2_pkg::ST_W0: begin
        ctrl.w0_load = 1'b1;
        ctrl.acc_op  = iirdf2_pkg::ACC_CLEAR;
      end
      iirdf2_pkg::ST_FF: begin
        ctrl.tap = cnt;
        if (cnt != '0) ctrl.acc_op = iirdf2_pkg::ACC_ADD;
      end
      iirdf2_pkg::ST_FF_DRAIN: ctrl.acc_op = iirdf2_pkg::ACC_ADD;
      iirdf2_pkg::ST_Y:        ctrl.y_load = out_free;
      default:                 busy = 1'b1;
    endcase
  end

endmodule

@@ hdl/iir_direct_form2_filter_top.sv @@
// Direct form II biquad (order 1 or 2) in fixed point: signed 16-bit samples,
// Q4.20 coefficients b0 b1 b2 a1 a2 written through the cfg port (index 0..4),
// 24-bit saturating delay-line words. One 24x24 multiplier and one accumulator
// are shared by all taps. Each sample passes through the feedback taps, w0,
// the feedforward taps and the result register, the multiply-accumulate
// sequence running one tap per cycle; a new sample is taken only once the
// last result is in the output register. in_stall stays high while a sample
// is in work; a finished word waits in the output register.
module iir_direct_form2_filter_top #(
  parameter int FILTER_ORDER = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  iirdf2_pkg::in_word_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output iirdf2_pkg::out_word_t               out_data,
  input  logic                                cfg_write,
  input  logic [iirdf2_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [iirdf2_pkg::COEF_W-1:0]       cfg_data
);

  logic signed [iirdf2_pkg::COEF_W-1:0] coef [iirdf2_pkg::NUM_REGS];
  logic signed [iirdf2_pkg::WORD_W-1:0] dl [FILTER_ORDER];
  logic signed [iirdf2_pkg::WORD_W-1:0] tapw [2];
  logic signed [iirdf2_pkg::WORD_W-1:0] w0;
  logic                                 sat_w0;
  logic                                 last_q;

  iirdf2_pkg::mac_ctrl_t                ctrl;
  logic                                 busy;
  logic                                 out_free;
  logic                                 accept;
  logic signed [iirdf2_pkg::COEF_W-1:0] coef_op;
  logic signed [iirdf2_pkg::WORD_W-1:0] word_op;
  logic signed [iirdf2_pkg::WORD_W-1:0] w0_word;
  logic                                 w0_ovf;
  logic signed [iirdf2_pkg::SAMPLE_WIDTH-1:0] y_sample;
  logic                                 y_ovf;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  iirdf2_ctrl #(
    .FILTER_ORDER (FILTER_ORDER)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  iirdf2_mac u_mac (
    .clk      (clk),
    .acc_op   (ctrl.acc_op),
    .coef     (coef_op),
    .word     (word_op),
    .x        (in_data.sample_in),
    .w0_word  (w0_word),
    .w0_ovf   (w0_ovf),
    .y_sample (y_sample),
    .y_ovf    (y_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[iirdf2_pkg::REG_B0] <= iirdf2_pkg::COEF_ONE;
      coef[iirdf2_pkg::REG_B1] <= '0;
      coef[iirdf2_pkg::REG_B2] <= '0;
      coef[iirdf2_pkg::REG_A1] <= '0;
      coef[iirdf2_pkg::REG_A2] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        iirdf2_pkg::REG_B0: coef[iirdf2_pkg::REG_B0] <= cfg_data;
        iirdf2_pkg::REG_B1: coef[iirdf2_pkg::REG_B1] <= cfg_data;
        iirdf2_pkg::REG_B2: coef[iirdf2_pkg::REG_B2] <= cfg_data;
        iirdf2_pkg::REG_A1: coef[iirdf2_pkg::REG_A1] <= cfg_data;
        iirdf2_pkg::REG_A2: coef[iirdf2_pkg::REG_A2] <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_tap
    if (i < FILTER_ORDER) begin : g_real
      assign tapw[i] = dl[i];
    end else begin : g_zero
      assign tapw[i] = '0;
    end
  end

  always_comb begin
    case ({ctrl.fb, ctrl.tap})
      {1'b0, 2'd0}: coef_op = coef[iirdf2_pkg::REG_B0];
      {1'b0, 2'd1}: coef_op = coef[iirdf2_pkg::REG_B1];
      {1'b0, 2'd2}: coef_op = coef[iirdf2_pkg::REG_B2];
      {1'b1, 2'd1}: coef_op = coef[iirdf2_pkg::REG_A1];
      {1'b1, 2'd2}: coef_op = coef[iirdf2_pkg::REG_A2];
      default:      coef_op = '0;
    endcase
  end

  always_comb begin
    case (ctrl.tap)
      2'd0:    word_op = w0;
      2'd1:    word_op = tapw[0];
      2'd2:    word_op = tapw[1];
      default: word_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILTER_ORDER; i++) dl[i] <= '0;
    end else if (accept && in_data.clear_state) begin
      for (int i = 0; i < FILTER_ORDER; i++) dl[i] <= '0;
    end else if (ctrl.y_load) begin
      dl[0] <= w0;
      for (int i = 1; i < FILTER_ORDER; i++) dl[i] <= dl[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) last_q <= in_data.last_in;
    if (ctrl.w0_load) begin
      w0     <= w0_word;
      sat_w0 <= w0_ovf;
    end
    if (ctrl.y_load) begin
      out_data.sample_out <= y_sample;
      out_data.saturated  <= sat_w0 | y_ovf;
      out_data.last_out   <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.y_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/iirdf2_checker.sv @@
module iirdf2_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input iirdf2_pkg::out_word_t            out_data
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input taken again right after accept");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word appeared with no sample in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !$rose(out_valid))
    else $error("output word appeared one cycle after accept");

endmodule

bind iir_direct_form2_filter_top iirdf2_checker u_iirdf2_checker (.*);

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FILTER_ORDER  = 2;
  localparam int SETTLE_CYCLES = 16;
  localparam int NO_IDLE_JOBS  = 60;
  localparam int RAND_PHASES   = 8;
  localparam int CYCLE_LIMIT   = 200000;

  localparam logic [iirdf2_pkg::REG_IDX_W-1:0] REG_SPARE_LO =
    iirdf2_pkg::REG_IDX_W'(iirdf2_pkg::NUM_REGS);
  localparam logic [iirdf2_pkg::REG_IDX_W-1:0] REG_SPARE_HI =
    iirdf2_pkg::REG_IDX_W'((1 << iirdf2_pkg::REG_IDX_W) - 1);

  localparam logic [iirdf2_pkg::COEF_W-1:0] COEF_MAX =
    {1'b0, {(iirdf2_pkg::COEF_W-1){1'b1}}};
  localparam logic [iirdf2_pkg::COEF_W-1:0] COEF_MIN =
    {1'b1, {(iirdf2_pkg::COEF_W-1){1'b0}}};

  typedef enum logic [1:0] {
    JOB_SAMPLE,
    JOB_WRITE,
    JOB_DRAIN
  } job_kind_t;

  typedef struct packed {
    job_kind_t                               kind;
    iirdf2_pkg::in_word_t                    word;
    logic [iirdf2_pkg::REG_IDX_W-1:0]        idx;
    logic [iirdf2_pkg::COEF_W-1:0]           val;
  } job_t;

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  iirdf2_pkg::in_word_t             in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  iirdf2_pkg::out_word_t            out_data;
  logic                             cfg_write = 1'b0;
  logic [iirdf2_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [iirdf2_pkg::COEF_W-1:0]    cfg_data  = '0;

  job_t                  pending_jobs[$];
  iirdf2_pkg::out_word_t expected_outputs[$];

  logic signed [iirdf2_pkg::COEF_W-1:0] coef_model [iirdf2_pkg::NUM_REGS];
  longint                               taps_model [FILTER_ORDER];

  int   error_count = 0;
  int   cycle_count = 0;
  int   quiet_cycles = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  logic no_idle = 1'b0;

  iir_direct_form2_filter_top #(
    .FILTER_ORDER(FILTER_ORDER)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_frac(longint v);
    return (v + (longint'(1) << (iirdf2_pkg::FRAC_W - 1))) >>> iirdf2_pkg::FRAC_W;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint ff_coef(int t);
    case (t)
      0:       return longint'(coef_model[iirdf2_pkg::REG_B0]);
      1:       return longint'(coef_model[iirdf2_pkg::REG_B1]);
      2:       return longint'(coef_model[iirdf2_pkg::REG_B2]);
      default: return 0;
    endcase
  endfunction

  function automatic longint fb_coef(int t);
    case (t)
      1:       return longint'(coef_model[iirdf2_pkg::REG_A1]);
      2:       return longint'(coef_model[iirdf2_pkg::REG_A2]);
      default: return 0;
    endcase
  endfunction

  function automatic iirdf2_pkg::out_word_t filter_step(iirdf2_pkg::in_word_t word);
    longint                acc;
    longint                rounded;
    longint                w0;
    longint                y;
    iirdf2_pkg::out_word_t res;
    if (word.clear_state) begin
      for (int t = 0; t < FILTER_ORDER; t++) taps_model[t] = 0;
    end
    acc = longint'($signed(word.sample_in)) * (longint'(1) << iirdf2_pkg::FRAC_W);
    for (int t = 1; t <= FILTER_ORDER; t++) acc -= fb_coef(t) * taps_model[t-1];
    rounded = round_frac(acc);
    w0 = clip(rounded, iirdf2_pkg::WORD_W);
    res.saturated = (w0 != rounded);
    acc = ff_coef(0) * w0;
    for (int t = 1; t <= FILTER_ORDER; t++) acc += ff_coef(t) * taps_model[t-1];
    rounded = round_frac(acc);
    y = clip(rounded, iirdf2_pkg::SAMPLE_WIDTH);
    res.saturated = res.saturated | (y != rounded);
    for (int t = FILTER_ORDER - 1; t >= 1; t--) taps_model[t] = taps_model[t-1];
    taps_model[0] = w0;
    res.sample_out = y[iirdf2_pkg::SAMPLE_WIDTH-1:0];
    res.last_out = word.last_in;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %0s", cycle_count, what);
    error_count++;
  endtask

  function automatic void add_sample(logic signed [iirdf2_pkg::SAMPLE_WIDTH-1:0] s,
                                     logic clr, logic lst);
    job_t job;
    job = '0;
    job.kind = JOB_SAMPLE;
    job.word.sample_in = s;
    job.word.clear_state = clr;
    job.word.last_in = lst;
    pending_jobs.push_back(job);
  endfunction

  function automatic void add_write(logic [iirdf2_pkg::REG_IDX_W-1:0] idx,
                                    logic [iirdf2_pkg::COEF_W-1:0] val);
    job_t job;
    job = '0;
    job.kind = JOB_WRITE;
    job.idx = idx;
    job.val = val;
    pending_jobs.push_back(job);
  endfunction

  function automatic void add_drain();
    job_t job;
    job = '0;
    job.kind = JOB_DRAIN;
    pending_jobs.push_back(job);
  endfunction

  function automatic logic [iirdf2_pkg::COEF_W-1:0] rand_coef(int mode);
    case (mode)
      0: return iirdf2_pkg::COEF_W'($urandom());
      1: return iirdf2_pkg::COEF_W'(int'($urandom_range(0, 1 << iirdf2_pkg::FRAC_W))
                                    - (1 << (iirdf2_pkg::FRAC_W - 1)));
      default: begin
        case ($urandom_range(0, 3))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return '0;
          default: return iirdf2_pkg::COEF_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [iirdf2_pkg::SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(0, 3))
      1: begin
        case ($urandom_range(0, 4))
          0:       return {1'b0, {(iirdf2_pkg::SAMPLE_WIDTH-1){1'b1}}};
          1:       return {1'b1, {(iirdf2_pkg::SAMPLE_WIDTH-1){1'b0}}};
          2:       return '0;
          3:       return iirdf2_pkg::SAMPLE_WIDTH'(1);
          default: return '1;
        endcase
      end
      2:       return iirdf2_pkg::SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
      default: return iirdf2_pkg::SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  always @(posedge clk) begin : driver
    job_t job;
    logic next_valid;
    logic next_write;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_write <= 1'b0;
      quiet_cycles = 0;
      send_gap = 0;
      for (int r = 0; r < iirdf2_pkg::NUM_REGS; r++) coef_model[r] = '0;
      coef_model[iirdf2_pkg::REG_B0] = iirdf2_pkg::COEF_ONE;
      for (int t = 0; t < FILTER_ORDER; t++) taps_model[t] = 0;
    end else begin
      next_valid = in_valid && in_stall;
      next_write = 1'b0;
      if (in_valid && !in_stall) expected_outputs.push_back(filter_step(in_data));
      if (expected_outputs.size() == 0 && !in_valid) quiet_cycles++;
      else quiet_cycles = 0;
      no_idle = pending_jobs.size() < NO_IDLE_JOBS;
      if (!next_valid && pending_jobs.size() != 0) begin
        job = pending_jobs[0];
        case (job.kind)
          JOB_SAMPLE: begin
            if (send_gap != 0) begin
              send_gap--;
            end else begin
              next_valid = 1'b1;
              in_data <= job.word;
              job = pending_jobs.pop_front();
              send_gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            end
          end
          JOB_WRITE: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              next_write = 1'b1;
              cfg_index <= job.idx;
              cfg_data <= job.val;
              if (job.idx < iirdf2_pkg::NUM_REGS) coef_model[job.idx] = job.val;
              job = pending_jobs.pop_front();
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE_CYCLES) job = pending_jobs.pop_front();
          end
        endcase
      end
      in_valid <= next_valid;
      cfg_write <= next_write;
    end
  end

  always @(posedge clk) begin : monitor
    iirdf2_pkg::out_word_t want;
    logic next_stall;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data));
        end else begin
          want = expected_outputs.pop_front();
          if (out_data.sample_out !== want.sample_out)
            report_mismatch($sformatf("sample_out %h, want %h",
                                      out_data.sample_out, want.sample_out));
          if (out_data.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, want %b",
                                      out_data.saturated, want.saturated));
          if (out_data.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %b, want %b",
                                      out_data.last_out, want.last_out));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
        if (!no_idle && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
      end
      out_stall <= next_stall;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int mode;
    int n;
    int hold_at;

    // defaults: pass-through with b0 at one
    add_write(REG_SPARE_LO, COEF_MAX);
    add_write(REG_SPARE_HI, COEF_MIN);
    add_sample(16'sh7FFF, 1'b0, 1'b1);
    add_sample(16'sh8000, 1'b0, 1'b0);
    add_sample(16'sh0000, 1'b0, 1'b1);
    add_sample(16'sh0001, 1'b0, 1'b0);
    add_sample(16'shFFFF, 1'b1, 1'b0);

    add_write(iirdf2_pkg::REG_B0, COEF_MAX);
    add_write(iirdf2_pkg::REG_B1, COEF_MIN);
    add_write(iirdf2_pkg::REG_B2, COEF_MAX);
    add_write(iirdf2_pkg::REG_A1, COEF_MIN);
    add_write(iirdf2_pkg::REG_A2, COEF_MAX);
    add_sample(16'sh7FFF, 1'b1, 1'b0);
    add_sample(16'sh7FFF, 1'b0, 1'b0);
    add_sample(16'sh8000, 1'b0, 1'b0);
    add_sample(16'sh7FFF, 1'b0, 1'b0);
    add_sample(16'sh8000, 1'b0, 1'b0);
    add_sample(16'sh0000, 1'b0, 1'b1);

    add_write(iirdf2_pkg::REG_B0, iirdf2_pkg::COEF_W'(262144));
    add_write(iirdf2_pkg::REG_B1, iirdf2_pkg::COEF_W'(524288));
    add_write(iirdf2_pkg::REG_B2, iirdf2_pkg::COEF_W'(262144));
    add_write(iirdf2_pkg::REG_A1, iirdf2_pkg::COEF_W'(-838861));
    add_write(iirdf2_pkg::REG_A2, iirdf2_pkg::COEF_W'(209715));
    add_sample(16'sd10000, 1'b1, 1'b0);
    add_sample(16'sd0, 1'b0, 1'b0);
    add_sample(16'sd0, 1'b0, 1'b0);
    add_sample(-16'sd20000, 1'b1, 1'b0);
    add_sample(16'sd0, 1'b0, 1'b0);
    add_sample(16'sd12345, 1'b0, 1'b1);

    for (int r = 0; r < iirdf2_pkg::NUM_REGS; r++)
      add_write(iirdf2_pkg::REG_IDX_W'(r), COEF_MIN);
    add_sample(16'sh7FFF, 1'b1, 1'b0);
    add_sample(16'sh0001, 1'b0, 1'b0);
    add_sample(16'shFFFF, 1'b0, 1'b0);
    add_sample(16'sh8000, 1'b0, 1'b1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = (p == RAND_PHASES - 1) ? 1 : p % 3;
      for (int r = 0; r < iirdf2_pkg::NUM_REGS; r++)
        add_write(iirdf2_pkg::REG_IDX_W'(r), rand_coef(mode));
      if ($urandom_range(0, 3) == 0)
        add_write(iirdf2_pkg::REG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  iirdf2_pkg::COEF_W'($urandom()));
      n = $urandom_range(50, 70);
      hold_at = $urandom_range(5, n - 5);
      for (int k = 0; k < n; k++) begin
        if (k == hold_at) add_drain();
        add_sample(rand_sample(), $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    while (pending_jobs.size() != 0 || in_valid || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0 && expected_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
